/* hdl/hts_pkg.sv */
// ----------------------------------------------------------------------------
// hts_pkg
// Shared types and character constants for the HTML tag strip line filter.
// ----------------------------------------------------------------------------
package hts_pkg;

  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_LT      = 8'h3c;
  localparam logic [7:0] CH_GT      = 8'h3e;
  localparam logic [7:0] CASE_MASK  = 8'h5f;
  localparam logic [7:0] CH_B       = 8'h42;
  localparam logic [7:0] CH_R       = 8'h52;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NL      = 8'h0a;
  localparam logic [7:0] CH_DEL_TOP = 8'h7f;

  localparam int MAX_RES = 3;

  // tag-open prefix tracker
  typedef enum logic [2:0] {
    BR_IDLE = 3'b001,
    BR_LT   = 3'b010,
    BR_LTB  = 3'b100
  } br_state_t;

  // results caused by one input byte, in order
  typedef struct packed {
    logic [1:0]                cnt;
    logic [MAX_RES-1:0][7:0]   bytes;
    logic [MAX_RES-1:0]        ends;
  } bundle_t;

  // write side of the queue
  typedef struct packed {
    logic    push;
    bundle_t data;
  } q_wr_t;

  // read side of the queue
  typedef struct packed {
    logic    valid;
    bundle_t data;
  } q_rd_t;

endpackage

/* hdl/hts_if.sv */
// ----------------------------------------------------------------------------
// hts_if
// Valid/ready channels carrying input bytes and filtered result items.
// ----------------------------------------------------------------------------
interface hts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface hts_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       line_end;
  logic       last;

  modport source (output valid, output out_byte, output line_end, output last, input ready);
  modport sink   (input valid, input out_byte, input line_end, input last, output ready);
endinterface

/* hdl/hts_front.sv */
// ----------------------------------------------------------------------------
// hts_front
// Classifies each byte, updates the quote/tag/line state and builds the
// bundle of results it causes.
// ----------------------------------------------------------------------------
module hts_front #(
  parameter int LINE_CAPACITY = 255
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     in_byte,
  input  logic           q_full,
  output hts_pkg::q_wr_t q_wr
);
  import hts_pkg::*;

  localparam int CNT_W = $clog2(LINE_CAPACITY + 1);

  logic             quote_r, quote_nxt;
  logic             tag_r, tag_nxt;
  br_state_t        br_r, br_nxt;
  logic [CNT_W-1:0] raw_r, raw_nxt;
  logic             pend_r, pend_nxt;
  logic             content_r, content_nxt;

  logic [7:0] rb [4];
  logic       re [4];
  logic [1:0] n;
  logic [7:0] m;
  logic       accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign m        = in_byte & CASE_MASK;

  always_comb begin
    quote_nxt   = quote_r;
    tag_nxt     = tag_r;
    br_nxt      = br_r;
    raw_nxt     = raw_r;
    pend_nxt    = pend_r;
    content_nxt = content_r;
    n           = 2'd0;
    for (int i = 0; i < 4; i++) begin
      rb[i] = 8'd0;
      re[i] = 1'b0;
    end

    // "<br" prefix across bytes
    case (br_r)
      BR_LT:   br_nxt = (m == CH_B) ? BR_LTB : BR_IDLE;
      BR_LTB: begin
        br_nxt = BR_IDLE;
        if (m == CH_R) begin
          if (pend_nxt) begin
            rb[n] = CH_SPACE;
            n     = n + 2'd1;
          end
          re[n]       = 1'b1;
          n           = n + 2'd1;
          raw_nxt     = '0;
          pend_nxt    = 1'b0;
          content_nxt = 1'b0;
        end
      end
      default: br_nxt = br_r;
    endcase

    if (in_byte == CH_QUOTE) quote_nxt = !quote_nxt;

    if (!quote_nxt && in_byte == CH_LT) begin
      tag_nxt = 1'b1;
      br_nxt  = BR_LT;
    end

    if (!tag_nxt) begin
      if (in_byte >= CH_SPACE && in_byte <= CH_DEL_TOP) begin
        raw_nxt = raw_nxt + CNT_W'(1);
        if (in_byte == CH_SPACE) begin
          pend_nxt = 1'b1;
        end else begin
          if (pend_nxt) begin
            rb[n]    = CH_SPACE;
            n        = n + 2'd1;
            pend_nxt = 1'b0;
          end
          rb[n]       = in_byte;
          n           = n + 2'd1;
          content_nxt = 1'b1;
        end
      end
      if (raw_nxt >= CNT_W'(LINE_CAPACITY) || in_byte == CH_NL) begin
        // blank lines are dropped on newline or overflow
        if (content_nxt) begin
          if (pend_nxt) begin
            rb[n] = CH_SPACE;
            n     = n + 2'd1;
          end
          re[n] = 1'b1;
          n     = n + 2'd1;
        end
        raw_nxt     = '0;
        pend_nxt    = 1'b0;
        content_nxt = 1'b0;
      end
    end

    if (!quote_nxt && in_byte == CH_GT) tag_nxt = 1'b0;
  end

  always_comb begin
    q_wr.push     = accept && (n != 2'd0);
    q_wr.data.cnt = n;
    for (int i = 0; i < MAX_RES; i++) begin
      q_wr.data.bytes[i] = rb[i];
      q_wr.data.ends[i]  = re[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quote_r   <= 1'b0;
      tag_r     <= 1'b0;
      br_r      <= BR_IDLE;
      raw_r     <= '0;
      pend_r    <= 1'b0;
      content_r <= 1'b0;
    end else if (accept) begin
      quote_r   <= quote_nxt;
      tag_r     <= tag_nxt;
      br_r      <= br_nxt;
      raw_r     <= raw_nxt;
      pend_r    <= pend_nxt;
      content_r <= content_nxt;
    end
  end

endmodule

/* hdl/hts_queue.sv */
// ----------------------------------------------------------------------------
// hts_queue
// Two-entry queue of result bundles between front and back.
// ----------------------------------------------------------------------------
module hts_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  hts_pkg::q_wr_t q_wr,
  output logic           q_full,
  output hts_pkg::q_rd_t q_rd,
  input  logic           q_pop
);
  import hts_pkg::*;

  bundle_t    mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign q_full     = (count_r == 2'd2);
  assign do_push    = q_wr.push && !q_full;
  assign do_pop     = q_pop && (count_r != 2'd0);
  assign q_rd.valid = (count_r != 2'd0);
  assign q_rd.data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= q_wr.data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

/* hdl/hts_back.sv */
// ----------------------------------------------------------------------------
// hts_back
// Walks the head bundle into the output register, one result per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module hts_back (
  input  logic           clk,
  input  logic           rst_n,
  input  hts_pkg::q_rd_t q_rd,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_byte,
  output logic           line_end,
  output logic           last
);
  import hts_pkg::*;

  logic [1:0] idx_r, idx_nxt;
  logic       vld_r, vld_nxt;
  logic [7:0] byte_r;
  logic       end_r;
  logic       last_r;
  logic       load;
  logic       is_last;

  assign load    = q_rd.valid && (!vld_r || out_ready);
  assign is_last = (idx_r == (q_rd.data.cnt - 2'd1));
  assign q_pop   = load && is_last;

  always_comb begin
    idx_nxt = idx_r;
    vld_nxt = vld_r;
    if (out_ready) vld_nxt = 1'b0;
    if (load) begin
      vld_nxt = 1'b1;
      idx_nxt = is_last ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= q_rd.data.bytes[idx_r];
      end_r  <= q_rd.data.ends[idx_r];
      last_r <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
      vld_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      vld_r <= vld_nxt;
    end
  end

  assign out_valid = vld_r;
  assign out_byte  = byte_r;
  assign line_end  = end_r;
  assign last      = last_r;

endmodule

/* hdl/html_tag_strip_line_filter.sv */
// An accepted byte's results pass through a queue entry, then the output register.
// Throughput: one byte per cycle while each byte causes at most one result and the
// output is not stalled; a byte causing several results holds the back end while
// the one-result-per-cycle output register walks them, absorbed by a two-bundle queue.
// Reset (rst_n low, synchronous) clears all filter state and empties the queue.
// ----------------------------------------------------------------------------
// html_tag_strip_line_filter
// Strips HTML tags and emits collapsed line text with line terminators.
// ----------------------------------------------------------------------------
module html_tag_strip_line_filter #(
  parameter int LINE_CAPACITY = 255
) (
  input  logic       clk,
  input  logic       rst_n,
  hts_in_if.sink     in_ch,
  hts_out_if.source  out_ch
);
  import hts_pkg::*;

  q_wr_t q_wr;
  q_rd_t q_rd;
  logic  q_full;
  logic  q_pop;

  hts_front #(
    .LINE_CAPACITY (LINE_CAPACITY)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_byte  (in_ch.in_byte),
    .q_full   (q_full),
    .q_wr     (q_wr)
  );

  hts_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_wr   (q_wr),
    .q_full (q_full),
    .q_rd   (q_rd),
    .q_pop  (q_pop)
  );

  hts_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_rd      (q_rd),
    .q_pop     (q_pop),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_byte  (out_ch.out_byte),
    .line_end  (out_ch.line_end),
    .last      (out_ch.last)
  );

endmodule

/* dv/hts_line_checker.sv */
// ----------------------------------------------------------------------------
// hts_line_checker
// Watches both channels of the tag strip filter. It tracks the filter state
// for every input transfer, queues the text items that each byte should
// produce, and compares every output transfer with the oldest queued item.
// ----------------------------------------------------------------------------
module hts_line_checker #(
  parameter int LINE_CAPACITY = 255
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_byte,
  input  logic       out_line_end,
  input  logic       out_last,
  output int         fail_count,
  output int         expected_count
);
  import hts_pkg::*;

  typedef struct packed {
    logic [7:0] text;
    logic       term;
    logic       fin;
  } line_item_t;

  line_item_t expected_items[$];
  line_item_t byte_items[$];

  logic       quote_on;
  logic       in_tag;
  logic       space_held;
  logic       has_text;
  br_state_t  br_seen;
  logic [11:0] raw_len;

  task automatic add_item(input logic [7:0] text, input logic term);
    line_item_t it;
    if (byte_items.size() < MAX_RES) begin
      it.text = text;
      it.term = term;
      it.fin  = 1'b0;
      byte_items.push_back(it);
    end
  endtask

  task automatic close_line(input logic keep_blank);
    if (keep_blank || has_text) begin
      if (space_held) add_item(CH_SPACE, 1'b0);
      add_item(8'h00, 1'b1);
    end
    raw_len    = '0;
    space_held = 1'b0;
    has_text   = 1'b0;
  endtask

  task automatic filter_byte(input logic [7:0] b);
    logic [7:0] folded;
    folded = b & CASE_MASK;
    byte_items.delete();

    // "<br" prefix, case folded, spans three consecutive transfers
    case (br_seen)
      BR_LT:  br_seen = (folded == CH_B) ? BR_LTB : BR_IDLE;
      BR_LTB: begin
        br_seen = BR_IDLE;
        if (folded == CH_R) close_line(1'b1);
      end
      default: ;
    endcase

    if (b == CH_QUOTE) quote_on = !quote_on;
    if (!quote_on && b == CH_LT) begin
      in_tag  = 1'b1;
      br_seen = BR_LT;
    end

    if (!in_tag) begin
      if (b >= CH_SPACE && b <= CH_DEL_TOP) begin
        raw_len++;
        if (b == CH_SPACE) begin
          space_held = 1'b1;
        end else begin
          if (space_held) begin
            add_item(CH_SPACE, 1'b0);
            space_held = 1'b0;
          end
          add_item(b, 1'b0);
          has_text = 1'b1;
        end
      end
      if (raw_len >= LINE_CAPACITY || b == CH_NL) close_line(1'b0);
    end

    if (!quote_on && b == CH_GT) in_tag = 1'b0;

    if (byte_items.size() > 0) byte_items[byte_items.size()-1].fin = 1'b1;
    foreach (byte_items[i]) expected_items.push_back(byte_items[i]);
  endtask

  always @(posedge clk) begin
    line_item_t want;
    if (!rst_n) begin
      quote_on   = 1'b0;
      in_tag     = 1'b0;
      br_seen    = BR_IDLE;
      raw_len    = '0;
      space_held = 1'b0;
      has_text   = 1'b0;
      expected_items.delete();
      fail_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_items.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected transfer: byte %02h end %0b last %0b",
                     out_byte, out_line_end, out_last);
          fail_count++;
        end else begin
          want = expected_items.pop_front();
          if (want.text != out_byte || want.term != out_line_end ||
              want.fin != out_last) begin
            if (fail_count < 10)
              $display("mismatch: expected byte %02h end %0b last %0b, got byte %02h end %0b last %0b",
                       want.text, want.term, want.fin, out_byte, out_line_end, out_last);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) filter_byte(in_byte);
    end
    expected_count <= expected_items.size();
  end

endmodule

/* dv/tb_html_tag_strip_line_filter.sv */
// ----------------------------------------------------------------------------
// tb_html_tag_strip_line_filter
// Feeds HTML bytes to the tag strip filter: a directed opening, long lines
// that overflow the line buffer, then random tags, text, quotes, <br> forms
// and noise, under random idling and back-pressure on both channels.
// ----------------------------------------------------------------------------
module tb_html_tag_strip_line_filter;
  import hts_pkg::*;

  localparam int LINE_CAPACITY = 255;
  localparam int RANDOM_BYTES  = 110;

  localparam logic [7:0] OPENING [25] = '{
    "a", CH_SPACE, CH_SPACE, "b", CH_SPACE, CH_NL,      // collapse, trailing space
    CH_SPACE, CH_SPACE, CH_NL,                          // blank line dropped
    CH_LT, CH_B, "r", CH_GT,                            // <Br> on empty line
    CH_LT, 8'hc2, 8'hd2, CH_GT,                         // high bytes fold to BR
    CH_QUOTE, CH_LT, CH_QUOTE,                          // quoted '<' is text
    CH_GT, 8'h00, 8'hff, CH_DEL_TOP, CH_NL              // stray '>', extremes
  };

  logic clk = 1'b0;
  logic rst_n;

  hts_in_if  in_ch ();
  hts_out_if out_ch ();

  int   fail_count;
  int   expected_count;
  int   bytes_sent;
  logic tx_idle_en;
  logic rx_idle_en;
  int   rx_hold_cycles;

  html_tag_strip_line_filter #(
    .LINE_CAPACITY(LINE_CAPACITY)
  ) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  hts_line_checker #(
    .LINE_CAPACITY(LINE_CAPACITY)
  ) line_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_byte        (in_ch.in_byte),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_byte       (out_ch.out_byte),
    .out_line_end   (out_ch.line_end),
    .out_last       (out_ch.last),
    .fail_count     (fail_count),
    .expected_count (expected_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        rx_hold_cycles--;
      end else begin
        out_ch.ready <= !(rx_idle_en && $urandom_range(99) < 19);
      end
    end
  end

  initial begin
    #400000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // printable byte that never opens a tag or toggles quotes; it may still be '>'
  function automatic logic [7:0] rand_text_char();
    logic [7:0] c;
    do
      c = 8'($urandom_range(32, 126));
    while (c == CH_LT || c == CH_QUOTE);
    return c;
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_byte(input logic [7:0] b);
    if (tx_idle_en && $urandom_range(99) < 19) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  // sender stays idle until every expected result has come out
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_count != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random_chunk();
    int n;
    case ($urandom_range(9))
      0, 1: begin
        n = $urandom_range(1, 6);
        repeat (n) send_byte(rand_text_char());
      end
      2: repeat ($urandom_range(1, 3)) send_byte(CH_SPACE);
      3: send_byte(CH_NL);
      4, 5: begin
        send_byte(CH_LT);
        repeat ($urandom_range(1, 4)) send_byte(rand_text_char());
        if ($urandom_range(1)) begin
          send_byte(CH_SPACE);
          send_byte("h");
          send_byte("=");
          send_byte(CH_QUOTE);
          repeat ($urandom_range(0, 3))
            send_byte($urandom_range(3) == 0 ? CH_GT : rand_text_char());
          send_byte(CH_QUOTE);
        end
        send_byte(CH_GT);
      end
      6: begin
        send_byte(CH_LT);
        case ($urandom_range(3))
          0: send_byte("b");
          1: send_byte(CH_B);
          2: send_byte(8'hc2);
          default: send_byte(rand_text_char());
        endcase
        case ($urandom_range(3))
          0: send_byte("r");
          1: send_byte(CH_R);
          2: send_byte(8'hd2);
          default: send_byte(rand_text_char());
        endcase
        if ($urandom_range(1)) send_byte("/");
        send_byte(CH_GT);
      end
      7: send_byte(8'($urandom_range(255)));
      8: begin
        send_byte(CH_QUOTE);
        repeat ($urandom_range(0, 4)) send_byte(rand_text_char());
        send_byte(CH_QUOTE);
      end
      default: begin
        if ($urandom_range(1)) send_byte(8'($urandom_range(128, 255)));
        else send_byte(8'($urandom_range(0, 31)));
      end
    endcase
  endtask

  initial begin
    int mark;
    in_ch.valid    = 1'b0;
    in_ch.in_byte  = 8'h00;
    tx_idle_en     = 1'b1;
    rx_idle_en     = 1'b1;
    rx_hold_cycles = 0;
    bytes_sent     = 0;
    rst_n          = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    foreach (OPENING[i]) send_byte(OPENING[i]);

    // overflow with content, then an all-space line that overflows
    repeat (LINE_CAPACITY + 5) send_byte(rand_text_char());
    send_byte(CH_NL);
    repeat (LINE_CAPACITY) send_byte(CH_SPACE);

    mark = bytes_sent;
    while (bytes_sent < mark + 30) send_random_chunk();

    // long hold-off on the output while bytes keep coming
    rx_hold_cycles = 80;
    repeat (24) send_byte(rand_text_char());
    wait_drained();

    // stretch with no idling on either side
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    while (bytes_sent < mark + 70) send_random_chunk();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;

    while (bytes_sent < mark + 24 + RANDOM_BYTES) send_random_chunk();

    in_ch.valid <= 1'b0;
    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && expected_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
